[src/rpc_pkg.sv]
// Shared types and constants for the region permission checker.
// No dependencies; imported by rpc_front, rpc_back and the top level.
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int unsigned MaxRegionsDefault = 16;
  localparam int unsigned CmdFifoDepth      = 2;
  localparam int unsigned AddrW             = 32;
  localparam int unsigned RightsW           = 3;
  localparam int unsigned ReqW              = 4;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    kind_e                kind;
    logic [AddrW-1:0]     region_start;
    logic [AddrW-1:0]     region_end;
    logic [RightsW-1:0]   region_rights;
    logic [AddrW-1:0]     query_address;
    logic [ReqW-1:0]      access_rights;
  } rpc_in_t;

  typedef struct packed {
    logic region_hit;
    logic access_granted;
  } rpc_out_t;

  // Classified item as it sits in the command queue.
  // Load: a = start, b = end, rights = region rights.
  // Query: a = address, rights = requested rights.
  typedef struct packed {
    kind_e              op;
    logic [AddrW-1:0]   a;
    logic [AddrW-1:0]   b;
    logic [ReqW-1:0]    rights;
  } rpc_cmd_t;

  // One region table entry as stored in the RAM.
  typedef struct packed {
    logic [AddrW-1:0]   start_addr;
    logic [AddrW-1:0]   end_addr;
    logic [RightsW-1:0] rights;
  } rpc_entry_t;

endpackage

[src/rpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the region table.
`timescale 1ns / 1ps

module rpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/rpc_fifo.sv]
// Short command queue between the classifying front and the table back end.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module rpc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/rpc_front.sv]
// Front end: takes input items, tracks the table fill count and turns each
// item into a queue command. Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_front
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = MaxRegionsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rpc_in_t                            in_data_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output rpc_cmd_t                           cmd_o,
  output logic [$clog2(MAX_REGIONS + 1)-1:0] cmd_cnt_o
);

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            is_load, full, accept;

  assign is_load = (in_data_i.kind == KIND_LOAD);
  assign full    = (cnt_q == CntW'(MAX_REGIONS));
  assign accept  = in_valid_i && in_ready_o;

  // A load into a full table is taken and dropped here; it never enters the queue.
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i && !(is_load && full);

  always_comb begin
    cmd_o.op     = in_data_i.kind;
    cmd_o.a      = is_load ? in_data_i.region_start : in_data_i.query_address;
    cmd_o.b      = in_data_i.region_end;
    cmd_o.rights = is_load ? {1'b0, in_data_i.region_rights} : in_data_i.access_rights;
  end

  // Load: write index. Query: number of entries to scan.
  assign cmd_cnt_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && is_load && !full) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[src/rpc_back.sv]
// Back end: writes loads into the region table and scans it for queries,
// one entry per cycle, first match wins. Depends on rpc_pkg and rpc_ram.
`timescale 1ns / 1ps

module rpc_back
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = MaxRegionsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  rpc_cmd_t                           cmd_i,
  input  logic [$clog2(MAX_REGIONS + 1)-1:0] cmd_cnt_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rpc_out_t                           out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IdxW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  back_state_e       state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [ReqW-1:0]   req_q, req_d;
  rpc_out_t          res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rpc_out_t          out_data_q, out_data_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_raddr;
  rpc_entry_t        wr_entry, rd_entry;
  logic              slot_free, match, grant, last;

  assign wr_entry.start_addr = cmd_i.a;
  assign wr_entry.end_addr   = cmd_i.b;
  assign wr_entry.rights     = cmd_i.rights[RightsW-1:0];

  rpc_ram #(
    .WIDTH ($bits(rpc_entry_t)),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_cnt_i[IdxW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  // Empty or inverted ranges never match. Request bit 3 is never granted.
  assign match = (rd_entry.start_addr <= addr_q) && (addr_q < rd_entry.end_addr);
  assign grant = ((req_q & ~{1'b0, rd_entry.rights}) == '0);
  assign last  = ((CntW'(idx_q) + CntW'(1)) == cnt_q);

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        // Entry 0 is read ahead so the scan starts on the next cycle.
        ram_raddr   = '0;
        if (cmd_valid_i) begin
          if (cmd_i.op == KIND_LOAD) begin
            ram_we = 1'b1;
          end else begin
            addr_d = cmd_i.a;
            req_d  = cmd_i.rights;
            cnt_d  = cmd_cnt_i;
            idx_d  = '0;
            if (cmd_cnt_i == '0) begin
              res_d   = '0;
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = last ? idx_q : idx_q + IdxW'(1);
        idx_d     = last ? idx_q : idx_q + IdxW'(1);
        if (match) begin
          res_d.region_hit     = 1'b1;
          res_d.access_granted = grant;
          state_d              = ST_DONE;
        end else if (last) begin
          res_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    addr_q     <= addr_d;
    req_q      <= req_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> CntW'(idx_q) < cnt_q)
    else $error("scan index past entry count");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside finish state");

  a_done_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && slot_free |=> state_q == ST_IDLE && out_valid_q)
    else $error("finished query not handed to output");
`endif

endmodule

[src/region_permission_checker_top.sv]
// Top level of the region permission checker: front end, command queue,
// table back end. Depends on rpc_pkg, rpc_front, rpc_fifo, rpc_back.
`timescale 1ns / 1ps

// Region permission checker. A load item (kind 0) appends a region
// [region_start, region_end) with its read/write/execute mask to a table of
// MAX_REGIONS entries; loads into a full table are dropped and no load gives
// a result. A query item (kind 1) yields one result: region_hit from the
// earliest loaded region containing query_address, access_granted when that
// region holds every requested right. A load is written into the table
// straight from the idle state. A query is taken in the idle state, then
// compared against the entries up to and including the first match (at most
// the entries loaded so far): the table sits in a single-port-read RAM
// scanned one entry per cycle. The result is posted once the output register
// is free. A two-entry command queue lets input keep flowing while a scan
// runs, and the output register holds a result until it is taken.
module region_permission_checker_top
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = MaxRegionsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rpc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rpc_out_t out_data_o
);

  localparam int unsigned CntW  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned QueueW = $bits(rpc_cmd_t) + CntW;

  logic              push_valid, push_ready, pop_valid, pop_ready;
  rpc_cmd_t          push_cmd, pop_cmd;
  logic [CntW-1:0]   push_cnt, pop_cnt;
  logic [QueueW-1:0] push_data, pop_data;

  rpc_front #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_cmd),
    .cmd_cnt_o   (push_cnt)
  );

  assign push_data = {push_cnt, push_cmd};

  rpc_fifo #(
    .WIDTH (QueueW),
    .DEPTH (CmdFifoDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_cnt = pop_data[QueueW-1 -: CntW];
  assign pop_cmd = pop_data[$bits(rpc_cmd_t)-1:0];

  rpc_back #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .cmd_cnt_i   (pop_cnt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
